>>> src/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies.
`default_nettype none

package bba_pkg;

    localparam int BLOCK_W         = 15;
    localparam int WORD_W          = 64;
    localparam int BIT_IDX_W       = 6;
    localparam int RESERVED_BLOCKS = 7;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [BLOCK_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [BLOCK_W-1:0] granted_block;
        logic               no_free_block;
        logic               bad_block_number;
    } t_rsp;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] idx;
    } t_ffs;

endpackage

`default_nettype wire

>>> src/bba_map_ram.sv
// Free-map word store: one write port, one read port with registered data.
// Uses bba_pkg.
`default_nettype none

module bba_map_ram #(
    parameter int DEPTH = 320,
    parameter int AW    = 9
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [bba_pkg::WORD_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [bba_pkg::WORD_W-1:0] o_rdata
);
    import bba_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/bba_ffs.sv
// Shared lowest-set-bit finder over one 64-bit word.
// Uses bba_pkg.
`default_nettype none

module bba_ffs (
    input  wire logic [bba_pkg::WORD_W-1:0] i_word,
    output bba_pkg::t_ffs                   o_res
);
    import bba_pkg::*;

    always_comb begin
        o_res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_res.found = 1'b1;
                o_res.idx   = BIT_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/bitmap_block_allocator_unit.sv
// First-fit free-block bitmap allocator, top level with sequencer and word summary.
// Uses bba_pkg, bba_map_ram, bba_ffs.
// Allocate: summary scan at 64 words a cycle, then the found word is read and updated.
// Release: word read, then written back; next request taken in the result cycle.
// Initialise and reset: a clearing pass of one map word a cycle (320 words at defaults).
// Synchronous active-low reset starts the clearing pass; no request is taken until it ends.
`default_nettype none

module bitmap_block_allocator_unit #(
    parameter int MAP_SECTORS       = 5,
    parameter int BLOCKS_PER_SECTOR = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire bba_pkg::t_req i_req,
    output logic       busy,
    output logic       o_done,
    output bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    localparam int TOTAL_BLOCKS = MAP_SECTORS * BLOCKS_PER_SECTOR;
    localparam int MAP_WORDS    = (TOTAL_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_CHUNKS   = (MAP_WORDS + WORD_W - 1) / WORD_W;
    localparam int SUM_BITS     = SUM_CHUNKS * WORD_W;
    localparam int SW           = $clog2(SUM_BITS);
    localparam int CW           = (SUM_CHUNKS > 1) ? $clog2(SUM_CHUNKS) : 1;
    localparam int LAST_BITS    = TOTAL_BLOCKS % WORD_W;

    localparam logic [WORD_W-1:0] FIRST_MASK = ~((WORD_W'(1) << RESERVED_BLOCKS) - WORD_W'(1));
    localparam logic [WORD_W-1:0] LAST_MASK  = (LAST_BITS == 0) ? {WORD_W{1'b1}}
                                             : ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
    localparam logic [SUM_BITS-1:0] SUM_INIT = {SUM_BITS{1'b1}} >> (SUM_BITS - MAP_WORDS);
    localparam logic [AW-1:0] LAST_WORD  = AW'(MAP_WORDS - 1);
    localparam logic [CW-1:0] LAST_CHUNK = CW'(SUM_CHUNKS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_PICK  = 5'b01000,
        ST_REL   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_init, n_init;
    logic [CW-1:0]       r_chunk, n_chunk;
    logic [SW-1:0]       r_word, n_word;
    logic [5:0]          r_bit, n_bit;
    logic [SUM_BITS-1:0] r_summary, n_summary;
    logic                r_done, n_done;
    t_rsp                r_rsp, n_rsp;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    logic [WORD_W-1:0]   ffs_in, chunk_bits, new_word;
    t_ffs                ffs_res;
    logic [SW-1:0]       scan_word;
    logic [31:0]         grant_num;

    function automatic logic [WORD_W-1:0] f_init_word(input logic [AW-1:0] w);
        logic [WORD_W-1:0] v;
        v = {WORD_W{1'b1}};
        if (w == '0) begin
            v = v & FIRST_MASK;
        end
        if (w == LAST_WORD) begin
            v = v & LAST_MASK;
        end
        return v;
    endfunction

    bba_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_ffs u_ffs (
        .i_word (ffs_in),
        .o_res  (ffs_res)
    );

    assign chunk_bits = r_summary[r_chunk * WORD_W +: WORD_W];
    assign ffs_in     = (r_state == ST_PICK) ? ram_rdata : chunk_bits;
    assign scan_word  = SW'(32'(r_chunk) * WORD_W + 32'(ffs_res.idx));
    assign grant_num  = 32'(r_word) * WORD_W + 32'(ffs_res.idx);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_init    = r_init;
        n_chunk   = r_chunk;
        n_word    = r_word;
        n_bit     = r_bit;
        n_summary = r_summary;
        n_done    = 1'b0;
        n_rsp     = '0;
        ram_we    = 1'b0;
        ram_waddr = r_word[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_word[AW-1:0];
        new_word  = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req.op)
                        OP_ALLOC: begin
                            n_chunk = '0;
                            n_state = ST_SCAN;
                        end
                        OP_RELEASE: begin
                            if (32'(i_req.block_number) >= 32'(TOTAL_BLOCKS)) begin
                                n_done                 = 1'b1;
                                n_rsp.bad_block_number = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_req.block_number >> BIT_IDX_W);
                                n_word    = SW'(i_req.block_number >> BIT_IDX_W);
                                n_bit     = i_req.block_number[BIT_IDX_W-1:0];
                                n_state   = ST_REL;
                            end
                        end
                        OP_INIT: begin
                            n_clr     = '0;
                            n_init    = 1'b1;
                            n_summary = SUM_INIT;
                            n_state   = ST_CLEAR;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = f_init_word(r_clr);
                if (r_clr == LAST_WORD) begin
                    n_done  = r_init;
                    n_init  = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            ST_SCAN: begin
                if (ffs_res.found) begin
                    ram_re    = 1'b1;
                    ram_raddr = scan_word[AW-1:0];
                    n_word    = scan_word;
                    n_state   = ST_PICK;
                end else if (r_chunk == LAST_CHUNK) begin
                    n_done              = 1'b1;
                    n_rsp.no_free_block = 1'b1;
                    n_state             = ST_IDLE;
                end else begin
                    n_chunk = r_chunk + CW'(1);
                end
            end
            ST_PICK: begin
                new_word            = ram_rdata & ~(WORD_W'(1) << ffs_res.idx);
                ram_we              = 1'b1;
                ram_wdata           = new_word;
                n_summary[r_word]   = |new_word;
                n_done              = 1'b1;
                n_rsp.granted_block = grant_num[BLOCK_W-1:0];
                n_state             = ST_IDLE;
            end
            ST_REL: begin
                new_word          = ram_rdata | (WORD_W'(1) << r_bit);
                ram_we            = 1'b1;
                ram_wdata         = new_word;
                n_summary[r_word] = 1'b1;
                n_done            = 1'b1;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_init    <= 1'b0;
            r_chunk   <= '0;
            r_summary <= SUM_INIT;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_init    <= n_init;
            r_chunk   <= n_chunk;
            r_summary <= n_summary;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_bit  <= n_bit;
        r_rsp  <= n_rsp;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

>>> verif/bba_alloc_checker.sv
// Request/result checker for the bitmap block allocator: keeps its own free-block map,
// predicts the result of every accepted request and compares results in order.
// Depends on bba_pkg.
module bba_alloc_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_busy,
    input  wire bba_pkg::t_req i_req,
    input  wire logic          i_done,
    input  wire bba_pkg::t_rsp i_rsp,
    output int                 o_mismatches,
    output int                 o_outstanding
);
    import bba_pkg::*;

    localparam int MAP_SECTORS       = 5;
    localparam int BLOCKS_PER_SECTOR = 4096;
    localparam int TOTAL_BLOCKS      = MAP_SECTORS * BLOCKS_PER_SECTOR;
    localparam int MAP_WORDS         = (TOTAL_BLOCKS + WORD_W - 1) / WORD_W;

    logic [WORD_W-1:0] free_map [MAP_WORDS];
    t_rsp              expected_rsp_q [$];
    int                mismatch_n = 0;
    int                pending_n  = 0;

    assign o_mismatches  = mismatch_n;
    assign o_outstanding = pending_n;

    function automatic void reinit_map();
        for (int b = 0; b < MAP_WORDS * WORD_W; b++) begin
            free_map[b / WORD_W][b % WORD_W] = (b >= RESERVED_BLOCKS) && (b < TOTAL_BLOCKS);
        end
    endfunction

    // first fit: lowest free block wins
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        bit   found;
        rsp   = '0;
        found = 1'b0;
        case (req.op)
            OP_ALLOC: begin
                for (int w = 0; w < MAP_WORDS && !found; w++) begin
                    if (free_map[w] != '0) begin
                        for (int i = 0; i < WORD_W && !found; i++) begin
                            if (free_map[w][i]) begin
                                free_map[w][i]    = 1'b0;
                                rsp.granted_block = BLOCK_W'(w * WORD_W + i);
                                found             = 1'b1;
                            end
                        end
                    end
                end
                rsp.no_free_block = !found;
            end
            OP_RELEASE: begin
                if (req.block_number >= TOTAL_BLOCKS) begin
                    rsp.bad_block_number = 1'b1;
                end else begin
                    free_map[req.block_number / WORD_W][req.block_number % WORD_W] = 1'b1;
                end
            end
            OP_INIT: reinit_map();
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void check_field(input string field_name, input int want, input int got);
        if (want != got) begin
            mismatch_n++;
            $display("%0t: %s expected %0d, got %0d", $time, field_name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            reinit_map();
            expected_rsp_q.delete();
        end else begin
            if (i_start && !i_busy) begin
                expected_rsp_q.push_back(apply_request(i_req));
            end
            if (i_done) begin
                if (expected_rsp_q.size() == 0) begin
                    mismatch_n++;
                    $display("%0t: result expected none, got granted %0d full %0b bad %0b",
                             $time, i_rsp.granted_block, i_rsp.no_free_block,
                             i_rsp.bad_block_number);
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("granted_block", want.granted_block, i_rsp.granted_block);
                    check_field("no_free_block", want.no_free_block, i_rsp.no_free_block);
                    check_field("bad_block_number", want.bad_block_number,
                                i_rsp.bad_block_number);
                end
            end
        end
        pending_n = expected_rsp_q.size();
    end

endmodule

>>> verif/bitmap_block_allocator_unit_tb.sv
// Testbench top for bitmap_block_allocator_unit: drives directed and random requests
// in bursts and gives the verdict.
// Depends on bba_pkg, bitmap_block_allocator_unit and bba_alloc_checker.
module bitmap_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam int         TOTAL_BLOCKS = 5 * 4096;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_REQS  = 1800;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int burst_left  = 0;

    always #1 i_clk = ~i_clk;

    bitmap_block_allocator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    bba_alloc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_done        (o_done),
        .i_rsp         (o_rsp),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request, then either stay in the burst or draw a gap and drop start if it is nonzero
    task automatic issue(input logic [1:0] op, input logic [BLOCK_W-1:0] blk);
        int gap;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= '{op: op, block_number: blk};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 7);
            if (gap != 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 12);
        end
    endtask

    initial begin : stimulus
        logic [1:0]         op;
        logic [BLOCK_W-1:0] blk;
        int                 roll;
        int                 pick;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '1);
        issue(OP_RELEASE, BLOCK_W'(0));
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, BLOCK_W'(8));
        issue(OP_RELEASE, BLOCK_W'(8));
        issue(OP_RELEASE, BLOCK_W'(TOTAL_BLOCKS - 1));
        issue(OP_RELEASE, BLOCK_W'(TOTAL_BLOCKS));
        issue(OP_RELEASE, '1);
        issue(OP_UNUSED, '1);
        issue(OP_UNUSED, '0);
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, BLOCK_W'(6));
        issue(OP_INIT, '1);
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, BLOCK_W'(5));
        issue(OP_ALLOC, '0);
        issue(OP_RELEASE, BLOCK_W'(TOTAL_BLOCKS - 1));
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);

        // reinitialise only in the second half
        for (int n = 0; n < RANDOM_REQS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                op = OP_ALLOC;
            end else if (roll < 92) begin
                op = OP_RELEASE;
            end else if (roll < 96 && n >= RANDOM_REQS / 2) begin
                op = OP_INIT;
            end else begin
                op = OP_UNUSED;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                blk = BLOCK_W'($urandom_range(0, 255));
            end else if (pick < 8) begin
                blk = BLOCK_W'($urandom_range(0, TOTAL_BLOCKS - 1));
            end else begin
                blk = BLOCK_W'($urandom());
            end
            issue(op, blk);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
